[rtl/core/ccdst_pkg.sv]
// ----------------------------------------------------------------------------
// ccdst_pkg
// Shared types, mode codes and calendar tables of the calendar clock.
// ----------------------------------------------------------------------------
`default_nettype none

package ccdst_pkg;

	// Operation codes carried by the request mode field
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_DAY   = 3'd1;
	localparam logic [2:0] MODE_MONTH = 3'd2;
	localparam logic [2:0] MODE_YEAR  = 3'd3;
	localparam logic [2:0] MODE_HOUR  = 3'd4;
	localparam logic [2:0] MODE_MIN   = 3'd5;
	localparam logic [2:0] MODE_SEC   = 3'd6;

	// Remainder unit: widest dividend is the weekday sum, widest divisor 60.
	// The quotient comes from a reciprocal scaled by 2^RCP_SH, exact for
	// every dividend below 2^DIV_W and every divisor the datapath uses.
	localparam int DIV_W      = 10;
	localparam int REM_W      = 6;
	localparam int CNT_W      = 2;
	localparam int DIV_CYCLES = 2;
	localparam int RCP_W      = 14;
	localparam int RCP_SH     = 16;
	localparam int QUO_W      = 8;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
		logic [2:0] weekday;
		logic       fallback;
	} ccdst_time_t;

	typedef struct packed {
		logic capture;
		logic tick;
		logic year_set;
		logic field_start;
		logic field_write;
		logic wday_start;
		logic wday_write;
		logic out_load;
	} ccdst_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       div_busy;
	} ccdst_stat_t;

	// Length of a month; out-of-range codes fall back to January
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		case (month) inside
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

	// Days in the year before the first of a month (non-leap)
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		case (month)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Rounded-up 2^16 / divisor for weekday, month, hour, month lengths and 60
	function automatic logic [RCP_W-1:0] recip_of(input logic [REM_W-1:0] divisor);
		logic [RCP_W-1:0] r;
		case (divisor)
			6'd7:    r = 14'd9363;
			6'd12:   r = 14'd5462;
			6'd24:   r = 14'd2731;
			6'd28:   r = 14'd2341;
			6'd29:   r = 14'd2260;
			6'd30:   r = 14'd2185;
			6'd31:   r = 14'd2115;
			default: r = 14'd1093;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/ccdst_if.sv]
// ----------------------------------------------------------------------------
// ccdst_req_if / ccdst_res_if
// Valid/ready channels of the calendar clock: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccdst_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic signed [8:0] set_value;

	modport source (output valid, mode, set_value, input ready);
	modport sink   (input valid, mode, set_value, output ready);
	modport mon    (input valid, ready, mode, set_value);
endinterface

interface ccdst_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] second_now;
	logic [5:0] minute_now;
	logic [4:0] hour_now;
	logic [4:0] day_now;
	logic [3:0] month_now;
	logic [7:0] year_now;
	logic [2:0] weekday_now;
	logic       fallback_done;

	modport source (output valid, second_now, minute_now, hour_now, day_now, month_now,
		year_now, weekday_now, fallback_done, input ready);
	modport sink   (input valid, second_now, minute_now, hour_now, day_now, month_now,
		year_now, weekday_now, fallback_done, output ready);
	modport mon    (input valid, ready, second_now, minute_now, hour_now, day_now,
		month_now, year_now, weekday_now, fallback_done);
endinterface

`default_nettype wire

[rtl/core/ccdst_divrem.sv]
// ----------------------------------------------------------------------------
// ccdst_divrem
// Remainder unit: reciprocal multiply, then multiply back and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdst_divrem (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ccdst_pkg::DIV_W-1:0] dividend,
	input  wire logic [ccdst_pkg::REM_W-1:0] divisor,
	output logic                             busy,
	output logic [ccdst_pkg::REM_W-1:0]      rem
);
	import ccdst_pkg::*;

	logic [DIV_W-1:0]       dvd_q;
	logic [REM_W-1:0]       dsr_q;
	logic [RCP_W+DIV_W-1:0] prod_q;
	logic [RCP_W+DIV_W-1:0] prod_d;
	logic [QUO_W-1:0]       quo;
	logic [REM_W+QUO_W-1:0] back;
	logic [DIV_W-1:0]       diff;
	logic [REM_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;

	// first step scales by the reciprocal, second takes off divisor times quotient
	always_comb begin
		prod_d = {{RCP_W{1'b0}}, dvd_q} * {{DIV_W{1'b0}}, recip_of(dsr_q)};
		quo    = prod_q[RCP_SH +: QUO_W];
		back   = {{QUO_W{1'b0}}, dsr_q} * {{REM_W{1'b0}}, quo};
		diff   = dvd_q - back[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_CYCLES);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
		end
		if (cnt_q == CNT_W'(DIV_CYCLES)) begin
			prod_q <= prod_d;
		end
		if (cnt_q == CNT_W'(1)) begin
			rem_q <= diff[REM_W-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/ccdst_dpath.sv]
// ----------------------------------------------------------------------------
// ccdst_dpath
// Time and date registers, tick carry logic, set wrapping and weekday sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdst_dpath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [2:0]             mode,
	input  wire logic signed [8:0]      set_value,
	input  wire ccdst_pkg::ccdst_cmd_t  cmd,
	output ccdst_pkg::ccdst_stat_t      stat,
	output ccdst_pkg::ccdst_time_t      res_time
);
	import ccdst_pkg::*;

	logic [2:0] mode_q;
	logic [7:0] val_q;
	logic [5:0] sec_q, min_q;
	logic [4:0] hour_q, day_q;
	logic [3:0] mon_q;
	logic [7:0] year_q;
	logic [2:0] wday_q;
	logic       flag_q;
	ccdst_time_t out_q;

	logic       leap;
	logic [4:0] dim;

	// tick results
	logic [5:0] sec_t, min_t;
	logic [4:0] hour_t, day_t;
	logic [3:0] mon_t;
	logic [7:0] year_t;
	logic [2:0] wday_t;
	logic       flag_t;
	logic [5:0] day_inc;
	logic       last_sun;

	// set and weekday operands
	logic [7:0]       set_sum;
	logic [REM_W-1:0] set_div;
	logic [8:0]       doy;
	logic [7:0]       y1;
	logic [5:0]       q4;
	logic [1:0]       q100;
	logic [DIV_W-1:0] wsum;
	logic             div_start;
	logic [DIV_W-1:0] div_dvd;
	logic [REM_W-1:0] div_dsr;
	logic             div_busy;
	logic [REM_W-1:0] rem;

	assign leap = (year_q[1:0] == 2'd0);
	assign dim  = month_days(mon_q, leap);

	// One-second advance with carries and the daylight-saving adjustments
	always_comb begin
		sec_t   = sec_q;
		min_t   = min_q;
		hour_t  = hour_q;
		day_t   = day_q;
		mon_t   = mon_q;
		year_t  = year_q;
		wday_t  = wday_q;
		flag_t  = flag_q;
		day_inc = {1'b0, day_q} + 6'd1;
		last_sun = 1'b0;
		if (sec_q != 6'd59) begin
			sec_t = sec_q + 6'd1;
		end else begin
			sec_t = '0;
			if (min_q != 6'd59) begin
				min_t = min_q + 6'd1;
			end else begin
				min_t  = '0;
				hour_t = hour_q + 5'd1;
				if (hour_t >= 5'd24) begin
					hour_t = '0;
					if (day_inc > {1'b0, dim}) begin
						day_t  = 5'd1;
						flag_t = 1'b0;
						if (mon_q >= 4'd12) begin
							mon_t  = 4'd1;
							year_t = year_q + 8'd1;
						end else begin
							mon_t = mon_q + 4'd1;
						end
					end else begin
						day_t = day_inc[4:0];
					end
					wday_t = (wday_q == 3'd7) ? 3'd1 : wday_q + 3'd1;
				end
				last_sun = (wday_t == 3'd7) && (mon_t == 4'd3 || mon_t == 4'd10) &&
					(day_t > 5'd24);
				if (mon_t == 4'd3 && hour_t == 5'd2 && last_sun) begin
					hour_t = 5'd3;
				end
				if (mon_t == 4'd10 && hour_t == 5'd3 && !flag_t && last_sun) begin
					hour_t = 5'd2;
					flag_t = 1'b1;
				end
			end
		end
	end

	// Wrap operands of the set operations
	always_comb begin
		case (mode_q)
			MODE_DAY: begin
				set_sum = val_q + {3'b0, dim} - 8'd1;
				set_div = {1'b0, dim};
			end
			MODE_MONTH: begin
				set_sum = val_q + 8'd11;
				set_div = 6'd12;
			end
			MODE_HOUR: begin
				set_sum = val_q + 8'd24;
				set_div = 6'd24;
			end
			default: begin
				set_sum = val_q + 8'd60;
				set_div = 6'd60;
			end
		endcase
	end

	// Weekday sum: year + leap days + day of year + 5
	always_comb begin
		doy = days_before(mon_q) + {4'b0, day_q} +
			{8'b0, (leap && mon_q >= 4'd3 && mon_q <= 4'd12)};
		y1  = year_q - 8'd1;
		if (year_q == 8'd0) begin
			q4   = '0;
			q100 = '0;
		end else begin
			q4   = y1[7:2];
			q100 = (y1 >= 8'd200) ? 2'd2 : ((y1 >= 8'd100) ? 2'd1 : 2'd0);
		end
		wsum = {2'b0, year_q} + {1'b0, doy} + {4'b0, q4} - {8'b0, q100} + 10'd5;
	end

	assign div_start = cmd.field_start | cmd.wday_start;
	assign div_dvd   = cmd.wday_start ? wsum : {2'b0, set_sum};
	assign div_dsr   = cmd.wday_start ? 6'd7 : set_div;

	ccdst_divrem u_divrem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			val_q  <= set_value[7:0];
		end
		if (cmd.out_load) begin
			out_q <= '{second: sec_q, minute: min_q, hour: hour_q, day: day_q,
				month: mon_q, year: year_q, weekday: wday_q, fallback: flag_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			min_q  <= '0;
			hour_q <= '0;
			day_q  <= 5'd1;
			mon_q  <= 4'd1;
			year_q <= '0;
			wday_q <= 3'd7;
			flag_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				sec_q  <= sec_t;
				min_q  <= min_t;
				hour_q <= hour_t;
				day_q  <= day_t;
				mon_q  <= mon_t;
				year_q <= year_t;
				wday_q <= wday_t;
				flag_q <= flag_t;
			end
			if (cmd.year_set) begin
				year_q <= val_q;
			end
			if (cmd.field_write) begin
				case (mode_q)
					MODE_DAY:   day_q  <= rem[4:0] + 5'd1;
					MODE_MONTH: mon_q  <= rem[3:0] + 4'd1;
					MODE_HOUR:  hour_q <= rem[4:0];
					MODE_MIN:   min_q  <= rem;
					MODE_SEC:   sec_q  <= rem;
					default:    ;
				endcase
			end
			if (cmd.wday_write) begin
				wday_q <= rem[2:0] + 3'd1;
			end
		end
	end

	assign stat.mode     = mode_q;
	assign stat.div_busy = div_busy;
	assign res_time      = out_q;

endmodule

`default_nettype wire

[rtl/core/ccdst_ctrl.sv]
// ----------------------------------------------------------------------------
// ccdst_ctrl
// Sequencer: accepts a request, steps the datapath, hands over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdst_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	input  wire ccdst_pkg::ccdst_stat_t stat,
	output ccdst_pkg::ccdst_cmd_t      cmd
);
	import ccdst_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_WSTART = 3'd3;
	localparam logic [2:0] S_WMOD   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.mode) inside
					MODE_DAY, MODE_MONTH, MODE_HOUR, MODE_MIN, MODE_SEC: begin
						cmd.field_start = 1'b1;
						state_d         = S_MOD;
					end
					MODE_TICK: begin
						cmd.tick = 1'b1;
						state_d  = S_DONE;
					end
					MODE_YEAR: begin
						cmd.year_set = 1'b1;
						state_d      = S_WSTART;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MOD: begin
				if (!stat.div_busy) begin
					cmd.field_write = 1'b1;
					state_d = (stat.mode == MODE_DAY || stat.mode == MODE_MONTH) ?
						S_WSTART : S_DONE;
				end
			end
			S_WSTART: begin
				cmd.wday_start = 1'b1;
				state_d        = S_WMOD;
			end
			S_WMOD: begin
				if (!stat.div_busy) begin
					cmd.wday_write = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

[rtl/core/calendar_clock_with_dst.sv]
// ----------------------------------------------------------------------------
// calendar_clock_with_dst
// Calendar clock for years 2000..2255 with EU-style daylight saving.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Transaction carries
//  req      in   valid/ready   mode (tick or field set), set_value
//  res      out  valid/ready   time and date after the step, fallback flag
//
//  One request at a time. A tick steps the clock; hour, minute and second
//  sets wrap the value in the remainder unit; day and month sets do so and
//  then recompute the weekday, a year set only recomputes it. The next
//  request is taken once the result is loaded. Wrapping and the weekday
//  remainder share one unit, a reciprocal multiply and a multiply-back.
//  Reset clears the clock to 2000-01-01 00:00:00, Sunday, flag clear.
//  The result sits in an output register: a stalled res holds it while the
//  next request is already taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_with_dst (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ccdst_req_if.sink   req,
	ccdst_res_if.source res
);
	import ccdst_pkg::*;

	ccdst_cmd_t  cmd;
	ccdst_stat_t stat;
	ccdst_time_t res_time;

	// Sequencer: owns both handshakes and steps the datapath
	ccdst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: clock state, carries, wrapping and weekday recompute
	ccdst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (req.mode),
		.set_value (req.set_value),
		.cmd       (cmd),
		.stat      (stat),
		.res_time  (res_time)
	);

	// Drive the result fields from the output register
	assign res.second_now    = res_time.second;
	assign res.minute_now    = res_time.minute;
	assign res.hour_now      = res_time.hour;
	assign res.day_now       = res_time.day;
	assign res.month_now     = res_time.month;
	assign res.year_now      = res_time.year;
	assign res.weekday_now   = res_time.weekday;
	assign res.fallback_done = res_time.fallback;

endmodule

`default_nettype wire

[rtl/core/ccdst_chk.sv]
// ----------------------------------------------------------------------------
// ccdst_chk
// Port-level checks of the calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdst_chk (
	input wire logic clk,
	input wire logic arst_n,
	ccdst_req_if.sink   req,
	ccdst_res_if.source res
);

	// Hold a stalled result unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.second_now) &&
		$stable(res.minute_now) && $stable(res.hour_now) && $stable(res.day_now) &&
		$stable(res.month_now) && $stable(res.year_now) && $stable(res.weekday_now) &&
		$stable(res.fallback_done))
		else $error("result changed while stalled");

	// Every delivered second, minute, hour and month lies in its range; day and weekday are nonzero
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.second_now < 6'd60 && res.minute_now < 6'd60 &&
		res.hour_now < 5'd24 && res.day_now != 5'd0 && res.month_now != 4'd0 &&
		res.month_now <= 4'd12 && res.weekday_now != 3'd0)
		else $error("result field out of range");

	// Drop ready after taking a request, in the execute state and the state after it
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready ##1 !req.ready)
		else $error("request taken while previous one in progress");

endmodule

bind calendar_clock_with_dst ccdst_chk u_ccdst_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.res    (res)
);

`default_nettype wire
